// ===== hw/rtl/bqe_pkg.sv =====
// ----------------------------------------------------------------------------
// bqe_pkg
// Shared types, widths and corner tables for the billboard quad expander.
// ----------------------------------------------------------------------------
`default_nettype none

package bqe_pkg;

  // Fixed-point formats
  localparam int VECTOR_FRAC_BITS = 14;
  localparam int VEC_W   = 16;                    // camera vector component
  localparam int COORD_W = 32;                    // Q16.16 coordinate
  localparam int SCALE_W = COORD_W + 1;           // +/- half size, exact
  localparam int PROD_W  = VEC_W + SCALE_W;       // full product
  localparam int TERM_W  = PROD_W - VECTOR_FRAC_BITS;
  localparam int SUM_W   = ((TERM_W > COORD_W) ? TERM_W : COORD_W) + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CORNER_W   = 3;

  localparam logic [VEC_W-1:0]    VEC_ONE     = VEC_W'(1 << VECTOR_FRAC_BITS);
  localparam logic [VEC_W-1:0]    VEC_ZERO    = '0;
  localparam logic [CORNER_W-1:0] CORNER_LAST = CORNER_W'(5);

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RIGHT_X = 3'd0,
    REG_RIGHT_Y = 3'd1,
    REG_RIGHT_Z = 3'd2,
    REG_UP_X    = 3'd3,
    REG_UP_Y    = 3'd4,
    REG_UP_Z    = 3'd5
  } bqe_reg_e;

  // Camera basis
  typedef struct packed {
    logic signed [VEC_W-1:0] right_x;
    logic signed [VEC_W-1:0] right_y;
    logic signed [VEC_W-1:0] right_z;
    logic signed [VEC_W-1:0] up_x;
    logic signed [VEC_W-1:0] up_y;
    logic signed [VEC_W-1:0] up_z;
  } bqe_cam_t;

  // Sideband that travels with each vertex
  typedef struct packed {
    logic                tex_u;
    logic                tex_v;
    logic [CORNER_W-1:0] corner;
    logic                quad_done;
    logic                frame_end;
  } bqe_tag_t;

  // One corner issued into the vertex datapath
  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic signed [SCALE_W-1:0] scale_r;
    logic signed [SCALE_W-1:0] scale_u;
    bqe_tag_t                  tag;
  } bqe_issue_t;

  // Per-corner attributes: negate right, negate up, u, v
  typedef struct packed {
    logic neg_r;
    logic neg_u;
    logic tex_u;
    logic tex_v;
  } bqe_corner_t;

  function automatic bqe_corner_t corner_attr(input logic [CORNER_W-1:0] k);
    bqe_corner_t c;
    case (k)
      3'd0:    c = '{neg_r: 1'b1, neg_u: 1'b1, tex_u: 1'b0, tex_v: 1'b1};
      3'd1:    c = '{neg_r: 1'b1, neg_u: 1'b0, tex_u: 1'b0, tex_v: 1'b0};
      3'd2:    c = '{neg_r: 1'b0, neg_u: 1'b1, tex_u: 1'b1, tex_v: 1'b1};
      3'd3:    c = '{neg_r: 1'b0, neg_u: 1'b1, tex_u: 1'b1, tex_v: 1'b1};
      3'd4:    c = '{neg_r: 1'b1, neg_u: 1'b0, tex_u: 1'b0, tex_v: 1'b0};
      3'd5:    c = '{neg_r: 1'b0, neg_u: 1'b0, tex_u: 1'b1, tex_v: 1'b0};
      default: c = '{neg_r: 1'b0, neg_u: 1'b0, tex_u: 1'b0, tex_v: 1'b0};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bqe_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bqe_cfg_regs
// Camera right and up vector registers behind a valid/ready write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bqe_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bqe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bqe_pkg::VEC_W-1:0]      cfg_data_i,
  output bqe_pkg::bqe_cam_t                   cam_o
);

  bqe_pkg::bqe_cam_t cam_q, cam_d;

  // Always ready; decode the index, ignore unmapped ones
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cam_d = cam_q;
    if (cfg_valid_i) begin
      case (bqe_pkg::bqe_reg_e'(cfg_index_i))
        bqe_pkg::REG_RIGHT_X: cam_d.right_x = cfg_data_i;
        bqe_pkg::REG_RIGHT_Y: cam_d.right_y = cfg_data_i;
        bqe_pkg::REG_RIGHT_Z: cam_d.right_z = cfg_data_i;
        bqe_pkg::REG_UP_X:    cam_d.up_x    = cfg_data_i;
        bqe_pkg::REG_UP_Y:    cam_d.up_y    = cfg_data_i;
        bqe_pkg::REG_UP_Z:    cam_d.up_z    = cfg_data_i;
        default:              cam_d         = cam_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q.right_x <= bqe_pkg::VEC_ONE;
      cam_q.right_y <= bqe_pkg::VEC_ZERO;
      cam_q.right_z <= bqe_pkg::VEC_ZERO;
      cam_q.up_x    <= bqe_pkg::VEC_ZERO;
      cam_q.up_y    <= bqe_pkg::VEC_ONE;
      cam_q.up_z    <= bqe_pkg::VEC_ZERO;
    end else begin
      cam_q <= cam_d;
    end
  end

  assign cam_o = cam_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bqe_corner_seq.sv =====
// ----------------------------------------------------------------------------
// bqe_corner_seq
// Holds one particle and issues its six corners, one per advancing cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bqe_corner_seq (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [bqe_pkg::COORD_W-1:0] center_x_i,
  input  wire logic signed [bqe_pkg::COORD_W-1:0] center_y_i,
  input  wire logic signed [bqe_pkg::COORD_W-1:0] center_z_i,
  input  wire logic signed [bqe_pkg::COORD_W-1:0] half_size_i,
  input  wire logic                               last_particle_i,
  input  wire logic                               adv_i,
  output bqe_pkg::bqe_issue_t                     issue_o
);

  logic                               busy_q, busy_d;
  logic [bqe_pkg::CORNER_W-1:0]       cnt_q, cnt_d;
  logic signed [bqe_pkg::COORD_W-1:0] cx_q, cy_q, cz_q, size_q;
  logic                               last_q;
  logic                               issue;
  logic                               final_corner;
  logic                               accept;
  logic signed [bqe_pkg::SCALE_W-1:0] scale_pos, scale_neg;
  bqe_pkg::bqe_corner_t               attr;

  assign issue        = busy_q & adv_i;
  assign final_corner = (cnt_q == bqe_pkg::CORNER_LAST);

  // Take the next particle as the final corner of the current one leaves
  assign in_stall_o = busy_q & ~(issue & final_corner);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (issue) begin
      if (final_corner) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + bqe_pkg::CORNER_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Capture the particle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q   <= center_x_i;
      cy_q   <= center_y_i;
      cz_q   <= center_z_i;
      size_q <= half_size_i;
      last_q <= last_particle_i;
    end
  end

  // Form +s and -s at full width so the most negative size negates exactly
  assign scale_pos = bqe_pkg::SCALE_W'(size_q);
  assign scale_neg = -scale_pos;
  assign attr      = bqe_pkg::corner_attr(cnt_q);

  always_comb begin
    issue_o.valid         = busy_q;
    issue_o.center_x      = cx_q;
    issue_o.center_y      = cy_q;
    issue_o.center_z      = cz_q;
    issue_o.scale_r       = attr.neg_r ? scale_neg : scale_pos;
    issue_o.scale_u       = attr.neg_u ? scale_neg : scale_pos;
    issue_o.tag.tex_u     = attr.tex_u;
    issue_o.tag.tex_v     = attr.tex_v;
    issue_o.tag.corner    = cnt_q;
    issue_o.tag.quad_done = final_corner;
    issue_o.tag.frame_end = final_corner & last_q;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bqe_axis_pipe.sv =====
// ----------------------------------------------------------------------------
// bqe_axis_pipe
// One coordinate axis: multiply, truncate and add, then saturate. Three
// register stages, all moving on the shared advance enable.
// ----------------------------------------------------------------------------
`default_nettype none

module bqe_axis_pipe (
  input  wire logic                               clk_i,
  input  wire logic                               adv_i,
  input  wire logic signed [bqe_pkg::COORD_W-1:0] center_i,
  input  wire logic signed [bqe_pkg::VEC_W-1:0]   vec_r_i,
  input  wire logic signed [bqe_pkg::VEC_W-1:0]   vec_u_i,
  input  wire logic signed [bqe_pkg::SCALE_W-1:0] scale_r_i,
  input  wire logic signed [bqe_pkg::SCALE_W-1:0] scale_u_i,
  output logic        [bqe_pkg::COORD_W-1:0]      coord_o
);

  localparam int F = bqe_pkg::VECTOR_FRAC_BITS;

  logic signed [bqe_pkg::PROD_W-1:0]  prod_r_q, prod_u_q;
  logic signed [bqe_pkg::PROD_W-1:0]  prod_r_d, prod_u_d;
  logic signed [bqe_pkg::COORD_W-1:0] center_q;
  logic signed [bqe_pkg::TERM_W-1:0]  term_r, term_u;
  logic signed [bqe_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic        [bqe_pkg::COORD_W-1:0] coord_q, coord_d;
  logic                               in_range;

  // Stage 1: full products
  assign prod_r_d = bqe_pkg::PROD_W'(vec_r_i * scale_r_i);
  assign prod_u_d = bqe_pkg::PROD_W'(vec_u_i * scale_u_i);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_r_q <= prod_r_d;
      prod_u_q <= prod_u_d;
      center_q <= center_i;
    end
  end

  // Stage 2: drop fraction bits (floor), exact sum
  assign term_r = $signed(prod_r_q[bqe_pkg::PROD_W-1:F]);
  assign term_u = $signed(prod_u_q[bqe_pkg::PROD_W-1:F]);
  assign sum_d  = bqe_pkg::SUM_W'(center_q) + bqe_pkg::SUM_W'(term_r)
                + bqe_pkg::SUM_W'(term_u);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q <= sum_d;
    end
  end

  // Stage 3: clamp to the signed 32-bit range
  assign in_range = (sum_q[bqe_pkg::SUM_W-1:bqe_pkg::COORD_W-1] == '0) ||
                    (sum_q[bqe_pkg::SUM_W-1:bqe_pkg::COORD_W-1] == '1);

  always_comb begin
    if (in_range) begin
      coord_d = sum_q[bqe_pkg::COORD_W-1:0];
    end else if (sum_q[bqe_pkg::SUM_W-1]) begin
      coord_d = {1'b1, {(bqe_pkg::COORD_W-1){1'b0}}};
    end else begin
      coord_d = {1'b0, {(bqe_pkg::COORD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

`default_nettype wire

// ===== hw/rtl/billboard_quad_expand_top.sv =====
// ----------------------------------------------------------------------------
// billboard_quad_expand_top
// Expands one particle into six camera-facing quad vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one particle: centre,
//   half size and a last-of-frame flag. Output channel (out_valid_o /
//   out_stall_i) carries one vertex per transaction, six per particle, in
//   the order bottom-left, top-left, bottom-right, bottom-right, top-left,
//   top-right. The sixth vertex has quad_done_o set and frame_end_o copies
//   the particle's last flag.
//   The first vertex leaves after the sequencer and the multiply, add and
//   saturate registers. Throughput: one vertex per cycle unless the receiver
//   stalls; the single vertex datapath (sequencer, multiply, add, saturate
//   stages) sets that rate. The next particle is taken as the sixth corner
//   issues, so quads follow with no gap. Reset returns the camera vectors to
//   right = (1,0,0), up = (0,1,0) and empties the pipeline. While the
//   receiver stalls with a vertex waiting, every stage holds; nothing is
//   dropped or repeated. The user must write camera registers through the
//   cfg port while the block is idle (not enforced); it is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module billboard_quad_expand_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [bqe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bqe_pkg::VEC_W-1:0]          cfg_data_i,
  // particle input
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [bqe_pkg::COORD_W-1:0] center_x_i,
  input  wire logic signed [bqe_pkg::COORD_W-1:0] center_y_i,
  input  wire logic signed [bqe_pkg::COORD_W-1:0] center_z_i,
  input  wire logic signed [bqe_pkg::COORD_W-1:0] half_size_i,
  input  wire logic                               last_particle_i,
  // vertex output
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [bqe_pkg::COORD_W-1:0]      vertex_x_o,
  output logic signed [bqe_pkg::COORD_W-1:0]      vertex_y_o,
  output logic signed [bqe_pkg::COORD_W-1:0]      vertex_z_o,
  output logic                                    tex_u_o,
  output logic                                    tex_v_o,
  output logic        [bqe_pkg::CORNER_W-1:0]     corner_index_o,
  output logic                                    quad_done_o,
  output logic                                    frame_end_o
);

  bqe_pkg::bqe_cam_t   cam;
  bqe_pkg::bqe_issue_t issue;
  logic                adv;
  logic                v1_q, v2_q, v3_q;
  bqe_pkg::bqe_tag_t   tag1_q, tag2_q, tag3_q;
  logic [bqe_pkg::COORD_W-1:0] coord_x, coord_y, coord_z;

  // Whole pipeline moves unless a finished vertex is being held
  assign adv = ~(v3_q & out_stall_i);

  bqe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cam_o       (cam)
  );

  bqe_corner_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .center_z_i      (center_z_i),
    .half_size_i     (half_size_i),
    .last_particle_i (last_particle_i),
    .adv_i           (adv),
    .issue_o         (issue)
  );

  bqe_axis_pipe u_axis_x (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .center_i  (issue.center_x),
    .vec_r_i   (cam.right_x),
    .vec_u_i   (cam.up_x),
    .scale_r_i (issue.scale_r),
    .scale_u_i (issue.scale_u),
    .coord_o   (coord_x)
  );

  bqe_axis_pipe u_axis_y (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .center_i  (issue.center_y),
    .vec_r_i   (cam.right_y),
    .vec_u_i   (cam.up_y),
    .scale_r_i (issue.scale_r),
    .scale_u_i (issue.scale_u),
    .coord_o   (coord_y)
  );

  bqe_axis_pipe u_axis_z (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .center_i  (issue.center_z),
    .vec_r_i   (cam.right_z),
    .vec_u_i   (cam.up_z),
    .scale_r_i (issue.scale_r),
    .scale_u_i (issue.scale_u),
    .coord_o   (coord_z)
  );

  // Advance valid bits alongside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= issue.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Carry the sideband through the same three stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag1_q <= issue.tag;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  assign out_valid_o    = v3_q;
  assign vertex_x_o     = coord_x;
  assign vertex_y_o     = coord_y;
  assign vertex_z_o     = coord_z;
  assign tex_u_o        = tag3_q.tex_u;
  assign tex_v_o        = tag3_q.tex_v;
  assign corner_index_o = tag3_q.corner;
  assign quad_done_o    = tag3_q.quad_done;
  assign frame_end_o    = tag3_q.frame_end;

  // A quad's corners leave back to back: no bubble inside a quad
  a_corner_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && corner_index_o != bqe_pkg::CORNER_LAST)
    |=> (out_valid_o && corner_index_o == $past(corner_index_o) + 3'd1))
    else $error("quad corner missing or out of order");

  // Frame end only ever rides on the closing vertex of a quad
  a_frame_end_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> (quad_done_o &&
      corner_index_o == bqe_pkg::CORNER_LAST))
    else $error("frame end outside closing vertex");

  // The input is never stalled while the sequencer is idle
  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!issue.valid) |-> !in_stall_o)
    else $error("input stalled while sequencer idle");

endmodule

`default_nettype wire
